FILE: rtl/core/dpht_pkg.sv
// ============================================================================
// dpht_pkg: shared types and constants of the depth-preferred hash table
// Entry layout, request and result records, operation codes and the state
// encoding of the controller.
// ============================================================================
package dpht_pkg;

  // Number of slots. The slot index is the low bits of the key, so this
  // must be a power of two.
  localparam int ENTRIES   = 4096;
  localparam int MOVE_BITS = 16;
  localparam int IDX_W     = $clog2(ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    FN_STORE = 2'd0,
    FN_PROBE = 2'd1,
    FN_READ  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_UPPER = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOK,
    ST_CLR_DONE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [63:0]          key;
    logic [1:0]           kind;
    logic signed [15:0]   value;
    logic [7:0]           depth;
    logic [MOVE_BITS-1:0] move;
  } entry_t;

  typedef struct packed {
    func_t              func;
    logic [63:0]        key;
    logic signed [15:0] new_value;
    logic [7:0]         search_depth;
    logic [1:0]         bound_kind;
    logic [15:0]        best_move;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] beta_bound;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               written;
    logic               slot_valid;
    logic [63:0]        slot_key;
    logic [1:0]         slot_kind;
    logic signed [15:0] slot_value;
    logic [7:0]         slot_depth;
    logic [15:0]        slot_move;
  } res_t;

  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic   wr_en;
    entry_t wr_data;
    res_t   res;
  } evl_t;

  function automatic idx_t idx_of(logic [63:0] key);
    return key[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/core/dpht_mem.sv
// ============================================================================
// dpht_mem: entry RAM of the hash table
// One write port and one read port; read data is registered and holds
// until the next read.
// ============================================================================
module dpht_mem
  import dpht_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem_r [ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/dpht_eval.sv
// ============================================================================
// dpht_eval: slot evaluation
// Decides the replacement of a store, the hit of a probe, and forms the
// result record from the slot read out of the entry RAM.
// ============================================================================
module dpht_eval
  import dpht_pkg::*;
(
  input  req_t   req,
  input  entry_t slot,
  output evl_t   evl
);

  function automatic res_t show(entry_t e);
    res_t r;
    r = '0;
    if (e.valid) begin
      r.slot_valid = 1'b1;
      r.slot_key   = e.key;
      r.slot_kind  = e.kind;
      r.slot_value = e.value;
      r.slot_depth = e.depth;
      r.slot_move  = 16'(e.move);
    end
    return r;
  endfunction

  entry_t new_entry;
  logic   replace;
  logic   match;
  logic   window_hit;

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.key   = req.key;
    new_entry.kind  = req.bound_kind;
    new_entry.value = req.new_value;
    new_entry.depth = req.search_depth;
    new_entry.move  = MOVE_BITS'(req.best_move);

    replace = !slot.valid || (req.search_depth > slot.depth);
    match   = slot.valid && (slot.key == req.key) && (slot.depth >= req.search_depth);
    window_hit = (slot.kind == KIND_EXACT) ||
                 ((slot.kind == KIND_UPPER) && (slot.value <= req.alpha_bound)) ||
                 ((slot.kind == KIND_LOWER) && (slot.value >= req.beta_bound));
  end

  always_comb begin
    evl.wr_en   = 1'b0;
    evl.wr_data = new_entry;
    evl.res     = '0;
    case (req.func)
      FN_STORE: begin
        evl.wr_en       = replace;
        evl.res         = show(replace ? new_entry : slot);
        evl.res.written = replace;
      end
      FN_PROBE: begin
        evl.res     = show(slot);
        evl.res.hit = match && window_hit;
      end
      FN_READ: begin
        evl.res = show(slot);
      end
      default: begin
        evl.res = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/dpht_ctrl.sv
// ============================================================================
// dpht_ctrl: request sequencer of the hash table
// Runs the clearing sweep, issues the slot read, writes back the evaluated
// entry and holds the result in the output register.
// ============================================================================
module dpht_ctrl
  import dpht_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  req_t     in_req,
  output req_t     req,
  input  evl_t     evl,
  output mem_req_t mem_req,
  output logic     out_tvalid,
  input  logic     out_tready,
  output res_t     out_res
);

  localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state_r, state_nxt;
  idx_t   sweep_r, sweep_nxt;
  logic   clr_r, clr_nxt;
  logic   out_valid_r, out_valid_nxt;
  res_t   out_res_r;
  req_t   req_r;

  logic   out_free;
  logic   accept;
  logic   load_out;
  res_t   load_res;

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (sweep_r == LAST_IDX) begin
          state_nxt = clr_r ? ST_CLR_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_req.func == FN_CLEAR) ? ST_SWEEP : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_req   = '0;
    load_out  = 1'b0;
    load_res  = '0;
    unique case (state_r)
      ST_SWEEP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = sweep_r;
      end
      ST_IDLE: begin
        in_tready       = 1'b1;
        mem_req.rd_en   = in_tvalid && (in_req.func != FN_CLEAR);
        mem_req.rd_addr = idx_of(in_req.key);
      end
      ST_LOOK: begin
        if (out_free) begin
          mem_req.wr_en   = evl.wr_en;
          mem_req.wr_addr = idx_of(req_r.key);
          mem_req.wr_data = evl.wr_data;
          load_out        = 1'b1;
          load_res        = evl.res;
        end
      end
      ST_CLR_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    sweep_nxt     = (state_r == ST_SWEEP) ? sweep_r + 1'b1 : '0;
    clr_nxt       = accept ? (in_req.func == FN_CLEAR) : clr_r;
    out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      clr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (load_out) begin
      out_res_r <= load_res;
    end
  end

  assign req        = req_r;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

endmodule

FILE: rtl/core/depth_preferred_hash_table_top.sv
// ============================================================================
// depth_preferred_hash_table_top: transposition table, depth-preferred
// Direct-mapped table of ENTRIES slots with store, probe, read and clear
// requests on a streaming interface.
// ============================================================================
// A store, probe or read request issues the read of its slot in the entry
// RAM (one write port, one read port) when it is accepted; from the
// registered slot, once the output register is free, it evaluates the slot,
// writes it back and loads the output register. No new request is taken
// before that. A clear request, and the reset itself, runs a sweep over the
// entry RAM that writes one slot a cycle, during which no request is taken;
// the clear's all-zero result follows the sweep. A finished result waits in
// the output register while the next request is accepted.
module depth_preferred_hash_table_top
  import dpht_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key[63:0], new_value[79:64], search_depth[87:80], best_move[103:88],
  // alpha_bound[119:104], beta_bound[135:120]
  input  logic [135:0] in_tdata,
  // func[1:0], bound_kind[3:2]
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // slot_key[63:0], slot_value[79:64], slot_depth[87:80], slot_move[103:88]
  output logic [103:0] out_tdata,
  // hit[0], written[1], slot_valid[2], slot_kind[4:3]
  output logic [4:0]   out_tuser
);

  req_t     in_req;
  req_t     req;
  entry_t   slot;
  evl_t     evl;
  mem_req_t mem_req;
  res_t     out_res;

  always_comb begin
    in_req.func         = func_t'(in_tuser[1:0]);
    in_req.bound_kind   = in_tuser[3:2];
    in_req.key          = in_tdata[63:0];
    in_req.new_value    = in_tdata[79:64];
    in_req.search_depth = in_tdata[87:80];
    in_req.best_move    = in_tdata[103:88];
    in_req.alpha_bound  = in_tdata[119:104];
    in_req.beta_bound   = in_tdata[135:120];
  end

  dpht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_req),
    .req        (req),
    .evl        (evl),
    .mem_req    (mem_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  dpht_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (slot)
  );

  dpht_eval u_eval (
    .req  (req),
    .slot (slot),
    .evl  (evl)
  );

  assign out_tdata = {out_res.slot_move, out_res.slot_depth, out_res.slot_value,
                      out_res.slot_key};
  assign out_tuser = {out_res.slot_kind, out_res.slot_valid, out_res.written,
                      out_res.hit};

  // A slot is never read and written in the same cycle, so the write-back
  // is always seen by the next request's read.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("entry RAM read and write in the same cycle");

  // Every accepted request other than clear reads its slot.
  a_read_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[1:0] != FN_CLEAR)) |->
      (mem_req.rd_en && (mem_req.rd_addr == idx_of(in_tdata[63:0]))))
    else $error("accepted request did not read its slot");

  // An accepted request drops in_tready, so no request follows it back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while the previous one is in flight");

endmodule
